FILE: rtl/bfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared constants and controller/datapath interface types for the
// FNV-1a double hashing Bloom filter.
// ----------------------------------------------------------------------------
package bfd_pkg;

    localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;
    localparam int          ROT_R     = 17;
    localparam int          ROW_W     = 32;
    localparam int          ROW_BW    = 5;

    localparam logic [1:0] MODE_QUERY = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic CFG_PROBE_COUNT = 1'b0;
    localparam logic CFG_FILTER_BITS = 1'b1;

    localparam logic [4:0]  PROBE_COUNT_RST = 5'd6;
    localparam logic [16:0] FILTER_BITS_RST = 17'd104;

    typedef struct packed {
        logic use_byte;
        logic hash_upd;
        logic key_end;
        logic hash_basis;
        logic mod_step;
        logic chk;
        logic is_add;
        logic probe_next;
        logic clr_start;
        logic clr_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic mod_done;
        logic last_probe;
        logic clr_done;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/bloom_filter_fnv_double_hash_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_fnv_double_hash_unit
// Bloom filter with FNV-1a double hashing over a RAM bit store.
//
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_ready      mode, key_byte, byte_valid, last_byte
// out       output     o_out_valid / i_out_ready    may_contain
// cfg       input      i_cfg_we                     i_cfg_idx, i_cfg_data
//
// A non-final key byte updates the hash. A key end runs k probes: each
// probe runs a bit-serial modulo (S_MOD), a RAM read (S_RD) and a check or
// read-modify-write (S_CHK); a query then loads the result register (S_OUT).
// Reset and clear mode sweep the store one 32-bit row per cycle, over
// ceil(MAX_FILTER_BITS/32) rows (2048 by default), with no input accepted.
// A result waits in the output register; a later query stalls only at its end.
// ----------------------------------------------------------------------------
module bloom_filter_fnv_double_hash_unit import bfd_pkg::*; #(
    parameter int MAX_FILTER_BITS = 65536,
    parameter int MAX_PROBES      = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_key_byte,
    input  logic        i_byte_valid,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_may_contain,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [16:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    bfd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_byte_valid (i_byte_valid),
        .i_last_byte  (i_last_byte),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    bfd_dpath #(
        .MAX_FILTER_BITS (MAX_FILTER_BITS),
        .MAX_PROBES      (MAX_PROBES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_key_byte    (i_key_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_may_contain (o_may_contain)
    );

endmodule

FILE: rtl/bfd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bfd_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_dpath
// Hash, probe sequence, bit-serial modulo, bit store access and result
// register of the Bloom filter.
// ----------------------------------------------------------------------------
module bfd_dpath import bfd_pkg::*; #(
    parameter int MAX_FILTER_BITS = 65536,
    parameter int MAX_PROBES      = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [7:0]  i_key_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_may_contain
);

    localparam int PW    = $clog2(MAX_FILTER_BITS);
    localparam int DEPTH = (MAX_FILTER_BITS + ROW_W - 1) / ROW_W;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_PROBES + 1);
    localparam logic [31:0] LIMIT = 32'(MAX_FILTER_BITS) & ~32'd7;

    logic [4:0]       r_pc;
    logic [16:0]      r_fb;
    logic [31:0]      r_hash, r_acc, r_delta, r_sh;
    logic [PW-1:0]    r_rem;
    logic [4:0]       r_bit;
    logic [KW-1:0]    r_pi;
    logic [AW-1:0]    r_caddr;
    logic             r_all;
    logic             r_oval, r_omay;

    logic [31:0]      prod, h_fin, nb32, nxt_acc;
    logic [PW:0]      n_ext, trial;
    logic [7:0]       k8;
    logic [KW-1:0]    k_last;
    logic [AW-1:0]    row;
    logic [ROW_W-1:0] rdata, mask;
    logic             ram_we;
    logic [AW-1:0]    waddr;
    logic [ROW_W-1:0] wdata;

    assign prod  = 32'((r_hash ^ {24'b0, i_key_byte}) * FNV_PRIME);
    assign h_fin = i_cmd.use_byte ? prod : r_hash;

    // Clamp filter size to [8, limit], multiple of eight.
    always_comb begin
        nb32 = {15'b0, r_fb[16:3], 3'b0};
        if (nb32 < 32'd8) nb32 = 32'd8;
        if (nb32 > LIMIT) nb32 = LIMIT;
        n_ext = (PW+1)'(nb32);
    end

    always_comb begin
        k8 = {3'b0, r_pc};
        if (k8 == 8'd0) k8 = 8'd1;
        if (k8 > 8'(MAX_PROBES)) k8 = 8'(MAX_PROBES);
        k_last = KW'(k8 - 8'd1);
    end

    assign trial   = {r_rem, r_sh[31]};
    assign nxt_acc = r_acc + r_delta;
    assign row     = AW'(r_rem >> ROW_BW);
    assign mask    = ROW_W'(1) << r_rem[ROW_BW-1:0];

    always_comb begin
        ram_we = 1'b0;
        waddr  = row;
        wdata  = rdata | mask;
        if (i_cmd.clr_wr) begin
            ram_we = 1'b1;
            waddr  = r_caddr;
            wdata  = '0;
        end else if (i_cmd.chk && i_cmd.is_add) begin
            ram_we = 1'b1;
        end
    end

    bfd_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (row),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= PROBE_COUNT_RST;
            r_fb    <= FILTER_BITS_RST;
            r_hash  <= FNV_BASIS;
            r_caddr <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PROBE_COUNT: r_pc <= i_cfg_data[4:0];
                    CFG_FILTER_BITS: r_fb <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.hash_upd) r_hash <= prod;
            if (i_cmd.key_end || i_cmd.hash_basis) r_hash <= FNV_BASIS;
            if (i_cmd.clr_start) r_caddr <= '0;
            else if (i_cmd.clr_wr) r_caddr <= r_caddr + AW'(1);
            if (i_cmd.out_load) r_oval <= 1'b1;
            else if (i_out_ready) r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_end) begin
            r_acc   <= h_fin;
            r_sh    <= h_fin;
            r_delta <= {h_fin[ROT_R-1:0], h_fin[31:ROT_R]};
            r_rem   <= '0;
            r_bit   <= '0;
            r_pi    <= '0;
            r_all   <= 1'b1;
        end else if (i_cmd.mod_step) begin
            // restoring remainder, one dividend bit per cycle
            if (trial >= n_ext) r_rem <= PW'(trial - n_ext);
            else                r_rem <= PW'(trial);
            r_sh  <= {r_sh[30:0], 1'b0};
            r_bit <= r_bit + 5'd1;
        end else if (i_cmd.probe_next) begin
            r_acc <= nxt_acc;
            r_sh  <= nxt_acc;
            r_rem <= '0;
            r_pi  <= r_pi + KW'(1);
        end
        if (i_cmd.chk && !i_cmd.is_add && ((rdata & mask) == '0)) r_all <= 1'b0;
        if (i_cmd.out_load) r_omay <= r_all;
    end

    assign o_sts.mod_done   = (r_bit == 5'd31);
    assign o_sts.last_probe = (r_pi == k_last);
    assign o_sts.clr_done   = (r_caddr == AW'(DEPTH - 1));
    assign o_sts.out_free   = !r_oval || i_out_ready;
    assign o_out_valid      = r_oval;
    assign o_may_contain    = r_omay;

endmodule

FILE: rtl/bfd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_ctrl
// Sequencer for byte hashing, probe loop, store clearing and result hand-off.
// ----------------------------------------------------------------------------
module bfd_ctrl import bfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_mode,
    input  logic       i_byte_valid,
    input  logic       i_last_byte,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_MOD, S_RD, S_CHK, S_OUT} t_state;

    t_state r_state, n_state;
    logic   r_add, n_add;
    logic   acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_add   = r_add;
        o_cmd.is_add = r_add;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (acc) begin
                    unique case (i_mode) inside
                        MODE_CLEAR: begin
                            o_cmd.clr_start  = 1'b1;
                            o_cmd.hash_basis = 1'b1;
                            n_state          = S_CLR;
                        end
                        MODE_QUERY, MODE_ADD: begin
                            o_cmd.use_byte = i_byte_valid;
                            if (!i_byte_valid || i_last_byte) begin
                                o_cmd.key_end = 1'b1;
                                n_add         = (i_mode == MODE_ADD);
                                n_state       = S_MOD;
                            end else begin
                                o_cmd.hash_upd = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_done) n_state = S_RD;
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_sts.last_probe) begin
                    n_state = r_add ? S_IDLE : S_OUT;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = S_MOD;
                end
            end
            S_OUT: begin
                // hold until the result register frees up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_add   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_add   <= n_add;
        end
    end

endmodule
